@@ hdl/lcct_pkg.sv @@
// Shared widths, reset values, controller states and command types for the LRU chunk tracker.
package lcct_pkg;

    localparam int REF_W         = 16;
    localparam int CHUNK_W       = 20;
    localparam int CAP_W         = 5;
    localparam int DEF_MAX_SLOTS = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_COMMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

@@ hdl/lcct_ctrl.sv @@
// Controller state machine: sequences capture and commit of each item and owns output valid.
module lcct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output lcct_pkg::dp_cmd_t cmd
);
    import lcct_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hdl/lcct_dp.sv @@
// Datapath: slot keys, recency ages, lookup, victim selection, update and result registers.
module lcct_dp #(
    parameter int MAX_SLOTS = lcct_pkg::DEF_MAX_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcct_pkg::dp_cmd_t           cmd,
    input  logic                        cfg_valid,
    input  logic [lcct_pkg::CAP_W-1:0]  cfg_data,
    input  logic [lcct_pkg::REF_W-1:0]  key_ref,
    input  logic [lcct_pkg::CHUNK_W-1:0] key_chunk,
    output logic                        res_hit,
    output logic                        res_ev_valid,
    output logic [lcct_pkg::REF_W-1:0]  res_ev_ref,
    output logic [lcct_pkg::CHUNK_W-1:0] res_ev_chunk,
    output logic [lcct_pkg::CAP_W-1:0]  res_occupancy
);
    import lcct_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int XW = (AW > CAP_W) ? AW : CAP_W;
    localparam int EW = (NW > CAP_W) ? NW : CAP_W;

    logic [CAP_W-1:0]   capacity_reg;
    logic [CAP_W-1:0]   count_reg;
    logic [CAP_W-1:0]   count_next;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] valid_next;
    logic [AW-1:0]      age_reg  [MAX_SLOTS];
    logic [AW-1:0]      age_next [MAX_SLOTS];
    logic [REF_W-1:0]   slot_ref_reg   [MAX_SLOTS];
    logic [CHUNK_W-1:0] slot_chunk_reg [MAX_SLOTS];

    logic [REF_W-1:0]     key_ref_reg;
    logic [CHUNK_W-1:0]   key_chunk_reg;
    logic [MAX_SLOTS-1:0] match_reg;
    logic [MAX_SLOTS-1:0] oldest_reg;
    logic [MAX_SLOTS-1:0] free_reg;
    logic [AW-1:0]        found_age_reg;
    logic                 hit_reg;
    logic                 full_reg;

    logic [MAX_SLOTS-1:0] match_next;
    logic [MAX_SLOTS-1:0] oldest_next;
    logic [MAX_SLOTS-1:0] free_next;
    logic [AW-1:0]        found_age_next;
    logic                 full_next;

    logic [MAX_SLOTS-1:0] target;
    logic                 evict;
    logic [REF_W-1:0]     ev_ref;
    logic [CHUNK_W-1:0]   ev_chunk;

    logic                 res_hit_reg;
    logic                 res_ev_valid_reg;
    logic [REF_W-1:0]     res_ev_ref_reg;
    logic [CHUNK_W-1:0]   res_ev_chunk_reg;
    logic [CAP_W-1:0]     res_occupancy_reg;

    assign res_hit       = res_hit_reg;
    assign res_ev_valid  = res_ev_valid_reg;
    assign res_ev_ref    = res_ev_ref_reg;
    assign res_ev_chunk  = res_ev_chunk_reg;
    assign res_occupancy = res_occupancy_reg;

    // lookup, oldest slot and first free slot, all from the current state
    always_comb
    begin
        logic [EW-1:0]        eff_cap;
        logic [XW-1:0]        last_age;
        logic [MAX_SLOTS-1:0] inv;
        eff_cap = EW'(capacity_reg);
        if (capacity_reg == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (eff_cap > EW'(MAX_SLOTS))
        begin
            eff_cap = EW'(MAX_SLOTS);
        end
        full_next      = EW'(count_reg) >= eff_cap;
        last_age       = XW'(count_reg) - XW'(1);
        found_age_next = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            match_next[i]  = valid_reg[i] && (slot_ref_reg[i] == key_ref)
                             && (slot_chunk_reg[i] == key_chunk);
            oldest_next[i] = valid_reg[i] && (XW'(age_reg[i]) == last_age);
            found_age_next = found_age_next | (match_next[i] ? age_reg[i] : '0);
        end
        inv       = ~valid_reg;
        free_next = inv & (~inv + MAX_SLOTS'(1));
    end

    always_comb
    begin
        evict    = !hit_reg && full_reg && (|oldest_reg);
        target   = evict ? oldest_reg : free_reg;
        ev_ref   = '0;
        ev_chunk = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            ev_ref   = ev_ref   | (oldest_reg[i] ? slot_ref_reg[i]   : '0);
            ev_chunk = ev_chunk | (oldest_reg[i] ? slot_chunk_reg[i] : '0);
        end
        if (!evict)
        begin
            ev_ref   = '0;
            ev_chunk = '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (cmd.commit)
        begin
            if (hit_reg)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (match_reg[i])
                    begin
                        age_next[i] = '0;
                    end
                    else if (valid_reg[i] && (age_reg[i] < found_age_reg))
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
            end
            else
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (target[i])
                    begin
                        age_next[i]   = '0;
                        valid_next[i] = 1'b1;
                    end
                    else if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
                if (!evict)
                begin
                    count_next = count_reg + CAP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
            valid_reg    <= '0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            count_reg <= count_next;
            valid_reg <= valid_next;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_ref_reg   <= key_ref;
            key_chunk_reg <= key_chunk;
            match_reg     <= match_next;
            oldest_reg    <= oldest_next;
            free_reg      <= free_next;
            found_age_reg <= found_age_next;
            hit_reg       <= |match_next;
            full_reg      <= full_next;
        end
        if (cmd.commit)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                if (!hit_reg && target[i])
                begin
                    slot_ref_reg[i]   <= key_ref_reg;
                    slot_chunk_reg[i] <= key_chunk_reg;
                end
            end
            res_hit_reg       <= hit_reg;
            res_ev_valid_reg  <= evict;
            res_ev_ref_reg    <= ev_ref;
            res_ev_chunk_reg  <= ev_chunk;
            res_occupancy_reg <= count_next;
        end
    end

endmodule

@@ hdl/lru_chunk_cache_tracker.sv @@
// Top level of the LRU chunk cache tracker: controller and datapath.
//
// Tracks up to MAX_SLOTS resident (ref_id, chunk_index) keys in least-recently-used
// order. Each accepted item is looked up against every slot in the cycle it is
// accepted and the lookup is registered; the commit step then applies the hit
// promotion or the miss insert (evicting the least recent key once occupancy has
// reached capacity) and loads the result register. The commit waits while a
// previous result is still held; no new item is taken before the commit. Capacity
// 0 acts as 1 and values above MAX_SLOTS act as MAX_SLOTS; lowering it does not
// flush keys. Write capacity only while no item is in flight.
module lru_chunk_cache_tracker #(
    parameter int MAX_SLOTS = lcct_pkg::DEF_MAX_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lcct_pkg::REF_W-1:0]   ref_id,
    input  logic [lcct_pkg::CHUNK_W-1:0] chunk_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit,
    output logic                         evicted_valid,
    output logic [lcct_pkg::REF_W-1:0]   evicted_ref_id,
    output logic [lcct_pkg::CHUNK_W-1:0] evicted_chunk,
    output logic [lcct_pkg::CAP_W-1:0]   occupancy,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lcct_pkg::CAP_W-1:0]   capacity
);
    import lcct_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    lcct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lcct_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (capacity),
        .key_ref       (ref_id),
        .key_chunk     (chunk_index),
        .res_hit       (hit),
        .res_ev_valid  (evicted_valid),
        .res_ev_ref    (evicted_ref_id),
        .res_ev_chunk  (evicted_chunk),
        .res_occupancy (occupancy)
    );

endmodule

@@ sim/lcct_checker.sv @@
// Checker for the LRU chunk cache tracker: mirrors residency and recency, compares every result.
module lcct_checker #(
    parameter int MAX_SLOTS = lcct_pkg::DEF_MAX_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [lcct_pkg::REF_W-1:0]   ref_id,
    input  logic [lcct_pkg::CHUNK_W-1:0] chunk_index,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         hit,
    input  logic                         evicted_valid,
    input  logic [lcct_pkg::REF_W-1:0]   evicted_ref_id,
    input  logic [lcct_pkg::CHUNK_W-1:0] evicted_chunk,
    input  logic [lcct_pkg::CAP_W-1:0]   occupancy,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [lcct_pkg::CAP_W-1:0]   capacity,
    output int                           pending,
    output int                           mismatches
);
    import lcct_pkg::*;

    typedef struct packed {
        logic               hit;
        logic               ev_valid;
        logic [REF_W-1:0]   ev_ref;
        logic [CHUNK_W-1:0] ev_chunk;
        logic [CAP_W-1:0]   occ;
    } lookup_res_t;

    logic [REF_W-1:0]   res_ref   [MAX_SLOTS];
    logic [CHUNK_W-1:0] res_chunk [MAX_SLOTS];
    logic               res_live  [MAX_SLOTS];
    int                 res_age   [MAX_SLOTS];
    int                 res_count;
    logic [CAP_W-1:0]   cap_reg;
    lookup_res_t        lookup_q [$];
    lookup_res_t        want;

    task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
        $display("%0t lcct_checker: %s got 0x%0h want 0x%0h", $time, what, got, exp_val);
        mismatches++;
    endtask

    // Look the key up, then promote it or insert it, evicting the least recent key when full.
    function automatic lookup_res_t lru_access(input logic [REF_W-1:0] r,
                                               input logic [CHUNK_W-1:0] c);
        lookup_res_t res;
        int found;
        int slot;
        int limit;
        int cap;
        res = '0;
        found = -1;
        slot = -1;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg));
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if (found < 0 && res_live[i] && res_ref[i] == r && res_chunk[i] == c)
            begin
                found = i;
            end
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            limit = res_age[found];
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                if (res_live[i] && res_age[i] < limit)
                begin
                    res_age[i]++;
                end
            end
            res_age[found] = 0;
        end
        else
        begin
            if (res_count >= cap)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (res_live[i] && (slot < 0 || res_age[i] > res_age[slot]))
                    begin
                        slot = i;
                    end
                end
                if (slot >= 0)
                begin
                    res.ev_valid = 1'b1;
                    res.ev_ref = res_ref[slot];
                    res.ev_chunk = res_chunk[slot];
                    res_live[slot] = 1'b0;
                    res_age[slot] = 0;
                    res_count--;
                end
            end
            if (slot < 0)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (slot < 0 && !res_live[i])
                    begin
                        slot = i;
                    end
                end
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (res_live[i])
                    begin
                        res_age[i]++;
                    end
                end
                res_ref[slot] = r;
                res_chunk[slot] = c;
                res_live[slot] = 1'b1;
                res_age[slot] = 0;
                res_count++;
            end
        end
        res.occ = res_count[CAP_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                res_ref[i] = '0;
                res_chunk[i] = '0;
                res_live[i] = 1'b0;
                res_age[i] = 0;
            end
            res_count = 0;
            cap_reg = CAP_RESET;
            lookup_q.delete();
            mismatches = 0;
        end
        else
        begin
            // Retire the older result first: it belongs to an item accepted earlier.
            if (out_valid && out_ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    flag_mismatch("result with no item pending", occupancy, 0);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (hit !== want.hit)
                    begin
                        flag_mismatch("hit", hit, want.hit);
                    end
                    if (evicted_valid !== want.ev_valid)
                    begin
                        flag_mismatch("evicted_valid", evicted_valid, want.ev_valid);
                    end
                    if (evicted_ref_id !== want.ev_ref)
                    begin
                        flag_mismatch("evicted_ref_id", evicted_ref_id, want.ev_ref);
                    end
                    if (evicted_chunk !== want.ev_chunk)
                    begin
                        flag_mismatch("evicted_chunk", evicted_chunk, want.ev_chunk);
                    end
                    if (occupancy !== want.occ)
                    begin
                        flag_mismatch("occupancy", occupancy, want.occ);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                lookup_q.insert(lookup_q.size(), lru_access(ref_id, chunk_index));
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = capacity;
            end
        end
        pending = lookup_q.size();
    end

endmodule

@@ sim/testbench.sv @@
// Top of the LRU chunk cache tracker testbench: clock, reset, stimulus and verdict.
module testbench;
    import lcct_pkg::*;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 9;
    localparam int POOL_MAX        = 32;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [REF_W-1:0]   ref_id = '0;
    logic [CHUNK_W-1:0] chunk_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic               evicted_valid;
    logic [REF_W-1:0]   evicted_ref_id;
    logic [CHUNK_W-1:0] evicted_chunk;
    logic [CAP_W-1:0]   occupancy;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CAP_W-1:0]   capacity = CAP_RESET;
    int                 pending;
    int                 mismatches;
    logic               no_idle = 1'b0;

    logic [REF_W-1:0]   pool_ref   [POOL_MAX];
    logic [CHUNK_W-1:0] pool_chunk [POOL_MAX];

    lru_chunk_cache_tracker i_dut (.*);

    lcct_checker i_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(99) >= 26);
    end

    // Enter and leave at a falling edge; hold the item until it is taken.
    task automatic send_access(input logic [REF_W-1:0] r, input logic [CHUNK_W-1:0] c);
        while (!no_idle && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ref_id <= r;
        chunk_index <= c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        capacity <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            begin
                stall = 0;
            end
            else
            begin
                stall++;
            end
        end
        $display("lru_chunk_cache_tracker test failed");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0]   phase_cap [NUM_PHASES];
        logic [REF_W-1:0]   last_ref;
        logic [CHUNK_W-1:0] last_chunk;
        logic [REF_W-1:0]   r;
        logic [CHUNK_W-1:0] c;
        int                 eff_cap;
        int                 pool_n;
        int                 roll;
        int                 pick;

        phase_cap = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd3, 5'd0, 5'd12, 5'd2, 5'd0};
        phase_cap[NUM_PHASES-1] = CAP_W'($urandom_range(31));
        last_ref = '0;
        last_chunk = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Capacity two: fill, hit, evict on keys that share a ref or a chunk.
        write_capacity(5'd2);
        send_access(16'h0000, 20'h00000);
        send_access(16'hFFFF, 20'hFFFFF);
        send_access(16'h0000, 20'h00000);
        send_access(16'h0000, 20'hFFFFF);
        send_access(16'hFFFF, 20'h00000);
        send_access(16'h0000, 20'hFFFFF);
        send_access(16'hFFFF, 20'h00000);
        // Capacity zero acts as one; occupancy is above it and must stay put.
        write_capacity(5'd0);
        send_access(16'h0001, 20'h00001);
        send_access(16'h0001, 20'h00001);
        send_access(16'h8000, 20'h80000);
        send_access(16'h0001, 20'h00001);
        send_access(16'hFFFE, 20'h7FFFF);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            no_idle <= (p == 3);
            eff_cap = (phase_cap[p] == 0) ? 1 : ((phase_cap[p] > DEF_MAX_SLOTS) ? DEF_MAX_SLOTS
                                                                                : phase_cap[p]);
            pool_n = eff_cap + 4;
            for (int i = 0; i < pool_n; i++)
            begin
                pool_ref[i] = REF_W'($urandom_range(65535));
                pool_chunk[i] = CHUNK_W'($urandom_range(1048575));
                // Share a ref id now and then so only the chunk tells keys apart.
                if (i > 0 && $urandom_range(3) == 0)
                begin
                    pool_ref[i] = pool_ref[i-1];
                end
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    r = REF_W'($urandom_range(65535));
                    c = CHUNK_W'($urandom_range(1048575));
                end
                else if (roll < 20)
                begin
                    r = last_ref;
                    c = last_chunk;
                end
                else
                begin
                    pick = $urandom_range(pool_n - 1);
                    r = pool_ref[pick];
                    c = pool_chunk[pick];
                end
                send_access(r, c);
                last_ref = r;
                last_chunk = c;
            end
        end
        in_valid <= 1'b0;
        no_idle <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("lru_chunk_cache_tracker test passed");
        end
        else
        begin
            $display("lru_chunk_cache_tracker test failed");
        end
        $finish;
    end

endmodule
